[rtl/mbsf_pkg.sv]
package mbsf_pkg;

	// Result kinds
	localparam logic [2:0] KIND_ABSORBED  = 3'd0;
	localparam logic [2:0] KIND_CHAN_MSG  = 3'd1;
	localparam logic [2:0] KIND_SYS_MSG   = 3'd2;
	localparam logic [2:0] KIND_SYSEX     = 3'd3;
	localparam logic [2:0] KIND_SYSEX_END = 3'd4;
	localparam logic [2:0] KIND_STRAY     = 3'd5;
	localparam logic [2:0] KIND_CUT_SHORT = 3'd6;

	// Status byte values
	localparam logic [7:0]  SYSEX_START    = 8'hF0;
	localparam logic [7:0]  SYSEX_END      = 8'hF7;
	localparam logic [7:0]  REALTIME_FIRST = 8'hF8;
	localparam logic [3:0]  HI_PROG_CHANGE = 4'hC;
	localparam logic [3:0]  HI_CHAN_PRESS  = 4'hD;
	localparam logic [15:0] SYSEX_CNT_MAX  = 16'hFFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_end;
	} mbsf_in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  status_byte;
		logic [4:0]  channel;
		logic [6:0]  first_data;
		logic [6:0]  second_data;
		logic        used_running_status;
		logic [15:0] sysex_length;
		logic        chunk_incomplete;
	} mbsf_out_t;

	// Framing state carried from item to item
	typedef struct packed {
		logic [7:0]  rs_byte;
		logic [1:0]  data_count;
		logic [6:0]  first_hold;
		logic        in_sysex;
		logic [15:0] sysex_cnt;
		logic        status_fresh;
	} mbsf_state_t;

	function automatic logic [4:0] chan_of(input logic [7:0] st);
		chan_of = {1'b0, st[3:0]} + 5'd1;
	endfunction

endpackage

[rtl/midi_byte_stream_framer_unit.sv]
// MIDI byte framer: takes one received byte per item and returns exactly one
// result item per byte, framing channel messages with running status, one-byte
// system messages, sysex (F0 to first F7, saturating length) and stray data.
// Each item passes through the input register and then the result register,
// and one item is accepted every cycle
// while the result side takes items; the single framing state register is
// updated as an item moves from the input register to the result register.
// in_stall rises only when both registers are full and out_stall is high.
// sysex_keep is written through cfg_wr_en/cfg_wr_data and resets to 1.
module midi_byte_stream_framer_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mbsf_pkg::mbsf_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mbsf_pkg::mbsf_out_t out_data,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data
);
	import mbsf_pkg::*;

	logic        sysex_keep_q;
	logic        valid_s1;
	mbsf_in_t    item_s1;
	logic        valid_s2;
	mbsf_out_t   res_s2;
	mbsf_state_t state_q;
	mbsf_state_t state_next;
	mbsf_out_t   res;
	logic        s2_open;
	logic        s1_open;
	logic        advance;

	// Handshake: each stage moves when the one after it can take the item
	assign s2_open  = !valid_s2 || !out_stall;
	assign s1_open  = !valid_s1 || s2_open;
	assign advance  = valid_s1 && s2_open;
	assign in_stall = !s1_open;

	// Hold the configuration bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sysex_keep_q <= 1'b1;
		end else if (cfg_wr_en) begin
			sysex_keep_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_open) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_open && in_valid) begin
			item_s1 <= in_data;
		end
	end

	mbsf_frame u_frame (
		.item       (item_s1),
		.state      (state_q),
		.sysex_keep (sysex_keep_q),
		.res        (res),
		.state_next (state_next)
	);

	// Advance framing state with each item that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_open) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// Sysex start clears running status, so both are never set together
	a_sysex_no_rs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.in_sysex |-> state_q.rs_byte == '0)
		else $error("running status held inside sysex");

	// Pending data always belongs to a stored channel status
	a_data_has_rs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.data_count != '0 |-> state_q.rs_byte != '0)
		else $error("pending data byte without running status");

	// Counter rests at zero outside sysex
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.in_sysex |-> state_q.sysex_cnt == '0)
		else $error("sysex counter nonzero outside sysex");

	// Input is held back only when both registers are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room in the pipeline");

	// State moves only when an item leaves the input register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("framing state changed without an item");

endmodule

[rtl/mbsf_frame.sv]
module mbsf_frame (
	input  mbsf_pkg::mbsf_in_t    item,
	input  mbsf_pkg::mbsf_state_t state,
	input  logic                  sysex_keep,
	output mbsf_pkg::mbsf_out_t   res,
	output mbsf_pkg::mbsf_state_t state_next
);
	import mbsf_pkg::*;

	logic [7:0]  b;
	logic [15:0] cnt_inc;
	logic        one_byte;
	logic        pending;

	assign b        = item.data_byte;
	assign cnt_inc  = (state.sysex_cnt == SYSEX_CNT_MAX) ? state.sysex_cnt
		: state.sysex_cnt + 16'd1;
	assign one_byte = (state.rs_byte[7:4] == HI_PROG_CHANGE)
		|| (state.rs_byte[7:4] == HI_CHAN_PRESS);

	// Frame one byte against the current state
	always_comb begin
		res        = '0;
		state_next = state;
		pending    = 1'b0;
		if (state.in_sysex) begin
			res.status_byte  = SYSEX_START;
			res.sysex_length = cnt_inc;
			state_next.sysex_cnt = cnt_inc;
			if (b == SYSEX_END) begin
				res.kind             = KIND_SYSEX_END;
				state_next.in_sysex  = 1'b0;
				state_next.sysex_cnt = '0;
			end else if (sysex_keep) begin
				res.kind       = KIND_SYSEX;
				res.first_data = b[6:0];
			end
		end else if (b >= REALTIME_FIRST) begin
			res.kind        = KIND_SYS_MSG;
			res.status_byte = b;
		end else if (b == SYSEX_START) begin
			state_next.rs_byte      = '0;
			state_next.data_count   = '0;
			state_next.status_fresh = 1'b0;
			state_next.in_sysex     = 1'b1;
			state_next.sysex_cnt    = 16'd1;
			res.status_byte         = SYSEX_START;
			res.sysex_length        = 16'd1;
			if (sysex_keep) begin
				res.kind = KIND_SYSEX;
			end
		end else if (b > SYSEX_START) begin
			state_next.rs_byte      = '0;
			state_next.data_count   = '0;
			state_next.status_fresh = 1'b0;
			res.kind                = KIND_SYS_MSG;
			res.status_byte         = b;
		end else if (b[7]) begin
			state_next.rs_byte      = b;
			state_next.data_count   = '0;
			state_next.status_fresh = 1'b1;
			res.status_byte         = b;
			res.channel             = chan_of(b);
		end else if (state.rs_byte == '0) begin
			res.kind = KIND_STRAY;
		end else begin
			res.status_byte = state.rs_byte;
			res.channel     = chan_of(state.rs_byte);
			if (one_byte || state.data_count != '0) begin
				res.kind = KIND_CHAN_MSG;
				if (one_byte) begin
					res.first_data = b[6:0];
				end else begin
					res.first_data  = state.first_hold;
					res.second_data = b[6:0];
				end
				res.used_running_status = ~state.status_fresh;
				state_next.status_fresh = 1'b0;
				state_next.data_count   = '0;
			end else begin
				state_next.first_hold = b[6:0];
				state_next.data_count = 2'd1;
			end
		end

		// Report what is still open after this byte
		pending = state_next.in_sysex || (state_next.data_count != '0)
			|| state_next.status_fresh;
		if (!state_next.in_sysex && res.kind == KIND_ABSORBED && pending
			&& state_next.rs_byte != '0) begin
			res.status_byte = state_next.rs_byte;
			res.channel     = chan_of(state_next.rs_byte);
		end
		if (item.chunk_end && pending && res.kind == KIND_ABSORBED) begin
			res.kind = KIND_CUT_SHORT;
			if (state_next.in_sysex) begin
				res.sysex_length = state_next.sysex_cnt;
			end
		end
		res.chunk_incomplete = item.chunk_end && pending;
	end

endmodule
